/* design/vrmt_pkg.sv */
// types, constants and helpers for the virtual region map table
// no dependencies; imported by virtual_region_map_table_core
package vrmt_pkg;

    localparam int DEFAULT_TABLE_ENTRIES = 64;

    localparam int ADDR_W   = 64;
    localparam int PAGES_W  = 37;
    localparam int FLAGS_W  = 7;
    localparam int ACQ_W    = 2;
    localparam int OWNER_W  = 16;
    localparam int BYTES_W  = 49;
    localparam int STATUS_W = 3;
    localparam int CMD_W    = 1;
    localparam int END_W    = ADDR_W + 1;

    localparam int IN_TDATA_W  = 208;
    localparam int OUT_TDATA_W = 136;

    localparam int FLAG_LARGE_BIT = 3;
    localparam int FLAG_GUARD_BIT = 4;
    localparam int FLAG_WC_BIT    = 5;
    localparam int FLAG_UC_BIT    = 6;

    localparam logic [CMD_W-1:0]   CMD_MAP     = 1'b0;
    localparam logic [CMD_W-1:0]   CMD_LOCATE  = 1'b1;
    localparam logic [ACQ_W-1:0]   ACQ_RESERVE = 2'd0;
    localparam logic [ACQ_W-1:0]   ACQ_STATIC  = 2'd2;

    localparam logic [ADDR_W-1:0]  ROOT_BASE  = 64'd0;
    localparam logic [PAGES_W-1:0] ROOT_PAGES = 37'd1;
    localparam logic [FLAGS_W-1:0] ROOT_FLAGS = 7'h18;
    localparam logic [OWNER_W-1:0] ROOT_OWNER = 16'hFFFF;

    localparam logic [OWNER_W-1:0] INV_OWNER_RESET = 16'hFFFF;
    localparam logic [PAGES_W-1:0] PAGES_MAX       = {PAGES_W{1'b1}};

    typedef enum logic [STATUS_W-1:0] {
        STS_OK         = 3'd0,
        STS_ZERO_SIZE  = 3'd1,
        STS_BAD_OWNER  = 3'd2,
        STS_CONTRA     = 3'd3,
        STS_UNALIGNED  = 3'd4,
        STS_OCCUPIED   = 3'd5,
        STS_FULL       = 3'd6,
        STS_NOT_FOUND  = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_END,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [PAGES_W-1:0] pages;
        logic [FLAGS_W-1:0] flags;
        logic [ACQ_W-1:0]   acq;
        logic [OWNER_W-1:0] owner;
    } entry_t;

    localparam entry_t ROOT_ENTRY = '{
        base:  ROOT_BASE,
        pages: ROOT_PAGES,
        flags: ROOT_FLAGS,
        acq:   ACQ_STATIC,
        owner: ROOT_OWNER
    };

    // exclusive end at 65 bits, page size from the large flag
    function automatic logic [END_W-1:0] region_end(
        input logic [ADDR_W-1:0]  base,
        input logic [PAGES_W-1:0] pages,
        input logic               lg_page
    );
        logic [57:0] len;
        len = lg_page ? {pages, 21'b0} : {9'b0, pages, 12'b0};
        return {1'b0, base} + {7'b0, len};
    endfunction

endpackage

/* design/virtual_region_map_table_core.sv */
// virtual region map table: map and locate commands over one region memory
// depends on vrmt_pkg
//
// channel  dir  beat fields (lowest bit up)
// s_axis   in   tuser: command; tdata: owner_id, virt_addr, phys_addr,
//               region_bytes, acquisition, page_flags
// m_axis   out  tdata: status, found_base, found_pages, found_flags,
//               found_acquisition, found_owner
// cfg      in   cfg_wr_data: invalid_owner_id, written when cfg_wr_en
//
// map rejected by a field check: status set in S_CHECK, then straight to S_DONE
// locate scan: S_CHECK to S_SCAN, map scan passes S_END first for the end sum,
//   one entry read per cycle from the single read port of the region memory
// reset: entry count 1, guard root held as a constant at entry 0,
//   memory needs no clearing pass since entries fill from the bottom
// one command at a time; the output register lets the next beat in
//   while a result waits, a later result holds until the register frees
module virtual_region_map_table_core #(
    parameter int TABLE_ENTRIES = vrmt_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // owner_id, virt_addr, phys_addr, region_bytes, acquisition, page_flags
    input  logic [vrmt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // command
    input  logic [vrmt_pkg::CMD_W-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // status, found_base, found_pages, found_flags, found_acquisition, found_owner
    output logic [vrmt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               cfg_wr_en,
    input  logic [vrmt_pkg::OWNER_W-1:0]       cfg_wr_data
);
    import vrmt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

    // control registers
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                p1_vld_reg, p1_vld_next;
    logic                p2_vld_reg, p2_vld_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OWNER_W-1:0]  inv_owner_reg;

    // request and result payload
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [OWNER_W-1:0]  owner_reg, owner_next;
    logic [ADDR_W-1:0]   virt_reg, virt_next;
    logic [ADDR_W-1:0]   phys_reg, phys_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;
    logic [ACQ_W-1:0]    acq_reg, acq_next;
    logic [FLAGS_W-1:0]  flags_reg, flags_next;
    logic [PAGES_W-1:0]  pages_reg, pages_next;
    logic [END_W-1:0]    req_end_reg, req_end_next;
    status_t             res_status_reg, res_status_next;
    logic                res_found_reg, res_found_next;
    entry_t              res_entry_reg, res_entry_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // scan pipeline
    entry_t              mem [TABLE_ENTRIES];
    entry_t              rd_data_reg;
    logic                rd_zero_reg;
    entry_t              ent1;
    entry_t              e_entry_reg;
    logic [END_W-1:0]    e_end_reg;

    logic                rd_en;
    logic                wr_en;
    entry_t              wr_data;

    logic                lg_page;
    logic                unaligned;
    logic [49:0]         round_sum;
    logic [37:0]         pages_wide;
    logic                hit;
    logic                scan_empty;
    entry_t              out_entry;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    assign ent1 = rd_zero_reg ? ROOT_ENTRY : rd_data_reg;

    assign lg_page   = flags_reg[FLAG_LARGE_BIT];
    assign unaligned = lg_page ? ((|virt_reg[20:0]) || (|phys_reg[20:0]))
                               : ((|virt_reg[11:0]) || (|phys_reg[11:0]));
    assign round_sum  = {1'b0, bytes_reg} + (lg_page ? 50'h1FFFFF : 50'hFFF);
    assign pages_wide = lg_page ? {9'b0, round_sum[49:21]} : round_sum[49:12];

    assign hit = (cmd_reg == CMD_LOCATE)
               ? ((virt_reg >= e_entry_reg.base) && ({1'b0, virt_reg} < e_end_reg))
               : (({1'b0, virt_reg} < e_end_reg) &&
                  ({1'b0, e_entry_reg.base} < req_end_reg));

    assign scan_empty = (rd_idx_reg == cnt_reg) && !p1_vld_reg && !p2_vld_reg;

    assign wr_data = '{
        base:  virt_reg,
        pages: pages_reg,
        flags: flags_reg,
        acq:   acq_reg,
        owner: owner_reg
    };

    assign out_entry = res_found_reg ? res_entry_reg : '0;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_idx_next     = rd_idx_reg;
        p1_vld_next     = 1'b0;
        p2_vld_next     = 1'b0;
        m_tvalid_next   = m_tvalid_reg;
        cmd_next        = cmd_reg;
        owner_next      = owner_reg;
        virt_next       = virt_reg;
        phys_next       = phys_reg;
        bytes_next      = bytes_reg;
        acq_next        = acq_reg;
        flags_next      = flags_reg;
        pages_next      = pages_reg;
        req_end_next    = req_end_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_entry_next  = res_entry_reg;
        m_tdata_next    = m_tdata_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;

        if (m_tvalid_reg && m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next    = s_axis_tuser;
                    owner_next  = s_axis_tdata[15:0];
                    virt_next   = s_axis_tdata[79:16];
                    phys_next   = s_axis_tdata[143:80];
                    bytes_next  = s_axis_tdata[192:144];
                    acq_next    = s_axis_tdata[194:193];
                    flags_next  = s_axis_tdata[201:195];
                    rd_idx_next = '0;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                res_found_next = 1'b0;
                pages_next     = pages_wide[37] ? PAGES_MAX : pages_wide[PAGES_W-1:0];
                state_next     = S_DONE;
                if (cmd_reg == CMD_LOCATE)
                begin
                    state_next = S_SCAN;
                end
                else if (bytes_reg == '0)
                begin
                    res_status_next = STS_ZERO_SIZE;
                end
                else if (owner_reg == inv_owner_reg)
                begin
                    res_status_next = STS_BAD_OWNER;
                end
                else if (flags_reg[FLAG_WC_BIT] && flags_reg[FLAG_UC_BIT])
                begin
                    res_status_next = STS_CONTRA;
                end
                else if (flags_reg[FLAG_GUARD_BIT] && (acq_reg != ACQ_RESERVE))
                begin
                    res_status_next = STS_CONTRA;
                end
                else if (unaligned)
                begin
                    res_status_next = STS_UNALIGNED;
                end
                else
                begin
                    state_next = S_END;
                end
            end
            S_END:
            begin
                req_end_next = region_end(virt_reg, pages_reg, lg_page);
                state_next   = S_SCAN;
            end
            S_SCAN:
            begin
                if (p2_vld_reg && hit)
                begin
                    res_found_next  = (cmd_reg == CMD_LOCATE);
                    res_status_next = (cmd_reg == CMD_LOCATE) ? STS_OK : STS_OCCUPIED;
                    res_entry_next  = e_entry_reg;
                    state_next      = S_DONE;
                end
                else if (scan_empty)
                begin
                    res_found_next = 1'b0;
                    state_next     = S_DONE;
                    if (cmd_reg == CMD_LOCATE)
                    begin
                        res_status_next = STS_NOT_FOUND;
                    end
                    else if (cnt_reg >= CNT_FULL)
                    begin
                        res_status_next = STS_FULL;
                    end
                    else
                    begin
                        res_status_next = STS_OK;
                        wr_en           = 1'b1;
                        cnt_next        = cnt_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    p2_vld_next = p1_vld_reg;
                    if (rd_idx_reg != cnt_reg)
                    begin
                        rd_en       = 1'b1;
                        p1_vld_next = 1'b1;
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0, out_entry.owner, out_entry.acq,
                                     out_entry.flags, out_entry.pages,
                                     out_entry.base, res_status_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= CNT_W'(1);
            rd_idx_reg    <= '0;
            p1_vld_reg    <= 1'b0;
            p2_vld_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            inv_owner_reg <= INV_OWNER_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_idx_reg   <= rd_idx_next;
            p1_vld_reg   <= p1_vld_next;
            p2_vld_reg   <= p2_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                inv_owner_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        owner_reg      <= owner_next;
        virt_reg       <= virt_next;
        phys_reg       <= phys_next;
        bytes_reg      <= bytes_next;
        acq_reg        <= acq_next;
        flags_reg      <= flags_next;
        pages_reg      <= pages_next;
        req_end_reg    <= req_end_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_entry_reg  <= res_entry_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // region memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cnt_reg[IDX_W-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
            rd_zero_reg <= (rd_idx_reg == '0);
        end
    end

    // entry end stage
    always_ff @(posedge clk)
    begin
        if (p1_vld_reg)
        begin
            e_entry_reg <= ent1;
            e_end_reg   <= region_end(ent1.base, ent1.pages, ent1.flags[FLAG_LARGE_BIT]);
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg >= CNT_W'(1)) && (cnt_reg <= CNT_FULL))
        else $error("entry count out of range");

    a_wr_bumps_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("memory write without count step");

    a_rd_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_idx_reg <= cnt_reg)
        else $error("scan index past fill count");

    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_vld_reg || p2_vld_reg) |-> (state_reg == S_SCAN))
        else $error("scan pipeline busy outside scan");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result loaded outside done");

endmodule
